// File: src/counting_sort_engine_macros.svh
// Assertion helpers used by the datapath (cse_dp).
`ifndef COUNTING_SORT_ENGINE_MACROS_SVH
`define COUNTING_SORT_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define CSE_CHK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CSE_CHK_ANY(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSE_CHK(lbl, clk, rstn, prop, msg)
`define CSE_CHK_ANY(lbl, clk, prop, msg)
`endif
`endif

// File: src/cse_pkg.sv
`default_nettype none
package cse_pkg;

	localparam int KEY_W            = 8;
	localparam int MAX_ITEMS_DEF    = 64;
	localparam int KEY_SPAN_DEF     = 256;
	localparam logic [KEY_W-1:0] MAX_VALUE_RST = 8'd100;

	typedef struct packed {
		logic [KEY_W-1:0] key_in;
		logic             last_in;
	} item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key_out;
		logic             last_out;
		logic             overflow;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_LOAD,
		ST_INC,
		ST_RD,
		ST_CHK,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;
		logic bump;
		logic rd;
		logic grab;
		logic push;
		logic wipe;
		logic step;
		logic clr_ptr;
		logic reset_set;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic zero;
		logic rem_one;
		logic ptr_end;
		logic out_free;
		logic tail;
	} stat_t;

endpackage
`default_nettype wire

// File: src/cse_ram.sv
`default_nettype none
module cse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: src/cse_ctrl.sv
`default_nettype none
module cse_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  wire cse_pkg::stat_t stat,
	output cse_pkg::cmd_t      cmd
);

	cse_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cse_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			// sweep the count table to zero after reset
			cse_pkg::ST_CLR: begin
				cmd.wipe = 1'b1;
				if (stat.ptr_end) begin
					cmd.clr_ptr = 1'b1;
					state_d     = cse_pkg::ST_LOAD;
				end else begin
					cmd.step = 1'b1;
				end
			end
			cse_pkg::ST_LOAD: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.take = 1'b1;
					state_d  = cse_pkg::ST_INC;
				end
			end
			cse_pkg::ST_INC: begin
				cmd.bump = 1'b1;
				state_d  = stat.last ? cse_pkg::ST_RD : cse_pkg::ST_LOAD;
			end
			cse_pkg::ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = cse_pkg::ST_CHK;
			end
			cse_pkg::ST_CHK: begin
				cmd.grab = 1'b1;
				if (stat.zero) begin
					cmd.step = 1'b1;
					state_d  = cse_pkg::ST_RD;
				end else begin
					state_d  = cse_pkg::ST_EMIT;
				end
			end
			cse_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					// entry drained: clear it on the way out
					if (stat.rem_one) begin
						cmd.wipe = 1'b1;
						if (stat.tail) begin
							cmd.reset_set = 1'b1;
							cmd.clr_ptr   = 1'b1;
							state_d       = cse_pkg::ST_LOAD;
						end else begin
							cmd.step = 1'b1;
							state_d  = cse_pkg::ST_RD;
						end
					end
				end
			end
			default: begin
				state_d = cse_pkg::ST_CLR;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/cse_dp.sv
`default_nettype none
`include "counting_sort_engine_macros.svh"
module cse_dp #(
	parameter int MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF,
	parameter int KEY_SPAN  = cse_pkg::KEY_SPAN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [cse_pkg::KEY_W-1:0]   cfg_wdata,
	input  wire cse_pkg::item_t              item,
	input  wire cse_pkg::cmd_t               cmd,
	output cse_pkg::stat_t                   stat,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output cse_pkg::res_t                    res
);

	localparam int KEY_W     = cse_pkg::KEY_W;
	localparam int KEY_LIM   = 2 ** KEY_W;
	localparam int TBL_DEPTH = (KEY_SPAN > KEY_LIM) ? KEY_LIM : KEY_SPAN;
	localparam int PTR_W     = $clog2(TBL_DEPTH);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam logic [KEY_W-1:0] KEY_TOP  = KEY_W'(TBL_DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_END  = PTR_W'(TBL_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ITEMS);

	logic [KEY_W-1:0] max_q;
	logic [PTR_W-1:0] key_q;
	logic             last_q;
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] sent_q;
	logic [CNT_W-1:0] num_q;
	logic             drop_q;
	logic             out_valid_q;
	cse_pkg::res_t    res_q;

	logic [KEY_W-1:0] key_lim;
	logic [KEY_W-1:0] key_clamp;
	logic             full;
	logic             tail;
	logic             ram_we;
	logic             ram_re;
	logic [PTR_W-1:0] ram_waddr;
	logic [PTR_W-1:0] ram_raddr;
	logic [CNT_W-1:0] ram_wdata;
	logic [CNT_W-1:0] ram_rdata;

	// clamp to the live max_value and to the top of the table
	always_comb begin
		key_lim   = (item.key_in > max_q) ? max_q : item.key_in;
		key_clamp = (key_lim > KEY_TOP) ? KEY_TOP : key_lim;
	end

	assign full = (num_q == CNT_FULL);
	assign tail = ((sent_q + CNT_W'(1)) == num_q);

	assign ram_re    = cmd.take | cmd.rd;
	assign ram_raddr = cmd.take ? key_clamp[PTR_W-1:0] : ptr_q;
	assign ram_we    = (cmd.bump & ~full) | cmd.wipe;
	assign ram_waddr = cmd.bump ? key_q : ptr_q;
	assign ram_wdata = cmd.bump ? (ram_rdata + CNT_W'(1)) : '0;

	cse_ram #(
		.WIDTH (CNT_W),
		.DEPTH (TBL_DEPTH)
	) u_count (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= cse_pkg::MAX_VALUE_RST;
			ptr_q       <= '0;
			rem_q       <= '0;
			sent_q      <= '0;
			num_q       <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (cmd.clr_ptr) begin
				ptr_q <= '0;
			end else if (cmd.step) begin
				ptr_q <= ptr_q + PTR_W'(1);
			end
			if (cmd.grab) begin
				rem_q <= ram_rdata;
			end else if (cmd.push) begin
				rem_q <= rem_q - CNT_W'(1);
			end
			if (cmd.reset_set) begin
				sent_q <= '0;
				num_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				if (cmd.push) begin
					sent_q <= sent_q + CNT_W'(1);
				end
				if (cmd.bump && !full) begin
					num_q <= num_q + CNT_W'(1);
				end
				if (cmd.bump && full) begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			key_q  <= key_clamp[PTR_W-1:0];
			last_q <= item.last_in;
		end
		if (cmd.push) begin
			res_q.key_out  <= KEY_W'(ptr_q);
			res_q.last_out <= tail;
			res_q.overflow <= drop_q;
		end
	end

	always_comb begin
		stat.last     = last_q;
		stat.zero     = (ram_rdata == '0);
		stat.rem_one  = (rem_q == CNT_W'(1));
		stat.ptr_end  = (ptr_q == PTR_END);
		stat.out_free = ~out_valid_q | res_ready;
		stat.tail     = tail;
	end

	assign res_valid = out_valid_q;
	assign res       = res_q;

	`CSE_CHK(a_push_free, clk, arst_n, cmd.push |-> stat.out_free, "beat pushed into a busy output register")
	`CSE_CHK(a_push_left, clk, arst_n, cmd.push |-> (rem_q != '0) && (sent_q < num_q), "beat pushed with nothing left")
	`CSE_CHK(a_set_done, clk, arst_n, cmd.push && tail |=> (num_q == '0) && !drop_q && (ptr_q == '0), "set state not cleared after last beat")
	`CSE_CHK(a_drop, clk, arst_n, cmd.bump && full |=> drop_q && (num_q == CNT_FULL), "dropped item not flagged")
	`CSE_CHK_ANY(a_port_clash, clk, !(cmd.bump && (cmd.push || cmd.wipe)), "count table write clash")

endmodule
`default_nettype wire

// File: src/counting_sort_engine.sv
`default_nettype none
// Stable counting sort of 8-bit keys. Items come in one beat at a time, each key clamped to
// max_value (and to KEY_SPAN-1); the beat with last_in set closes the set and starts output.
// Loading each item is a read-modify-write of the count table RAM; the next item is taken only
// after that write. Sorting then walks the count table from key 0 to the largest key present:
// each entry visited is read and checked, and a nonzero entry emits its beats as the output
// register frees, all bound by the single count RAM. Results come out ascending, last_out on the
// final beat, overflow set on every beat of a set that lost items past MAX_ITEMS. After reset the
// count table is swept to zero, one entry per cycle over min(KEY_SPAN, 256) entries (256 by
// default), during which no item is taken; max_value can be written at any idle time.
module counting_sort_engine #(
	parameter int MAX_ITEMS = cse_pkg::MAX_ITEMS_DEF,
	parameter int KEY_SPAN  = cse_pkg::KEY_SPAN_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [cse_pkg::KEY_W-1:0] cfg_wdata,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire cse_pkg::item_t            item,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output cse_pkg::res_t                  res
);

	cse_pkg::cmd_t  cmd;
	cse_pkg::stat_t stat;

	cse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	cse_dp #(
		.MAX_ITEMS (MAX_ITEMS),
		.KEY_SPAN  (KEY_SPAN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
`default_nettype wire
